[rtl/core/jtcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtcf_pkg
// Shared constants, types and command/status structs of the trailing-comma
// filter.
// ----------------------------------------------------------------------------
package jtcf_pkg;

  localparam int SPACE_DEPTH = 16;
  localparam int CNT_W = $clog2(SPACE_DEPTH + 1);
  localparam int IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // output byte source select
  localparam logic [1:0] SEL_COMMA = 2'd0;
  localparam logic [1:0] SEL_BUF   = 2'd1;
  localparam logic [1:0] SEL_TAIL  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic [1:0] sel;
    logic       last;
    logic       idx_inc;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic comma_nxt;
    logic buf_nxt;
    logic tail_nxt;
    logic buf_any;
    logic tail;
    logic idx_last;
  } dp_sts_t;

endpackage

[rtl/core/json_trailing_comma_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_trailing_comma_filter
// Streaming JSON filter that drops commas directly before a closing brace or
// bracket (whitespace in between allowed), outside string literals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one text byte per request, with
//   in_end_of_body set on the last byte of a body. Output channel
//   out_valid/out_ready carries the cleaned bytes; out_last_of_run marks the
//   last result of a request, out_body_done the final byte of a body and
//   out_whitespace_overflow every result of a request whose whitespace byte
//   found the 16-entry buffer full (the comma is then kept).
//   A request is accepted in the idle state; its results (0 to SPACE_DEPTH + 2)
//   then leave one per cycle while the output register is free.
//   A held comma and its whitespace produce no results until released. The
//   first result is loaded into the output register from the state entered
//   after the accept, once that register is free.
//   The next request is taken once the last result of the previous one is
//   in the output register, even if that result is not yet taken.
//   When the receiver stalls, the sequencer waits on the output register.
//   Reset (rst_n low, synchronous) clears string, escape and held-comma state
//   and empties the output register.
// ----------------------------------------------------------------------------
module json_trailing_comma_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_body,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_body_done,
  output logic       out_whitespace_overflow
);
  import jtcf_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  jtcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jtcf_datapath u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_data_byte            (in_data_byte),
    .in_end_of_body          (in_end_of_body),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_byte                (out_byte),
    .out_last_of_run         (out_last_of_run),
    .out_body_done           (out_body_done),
    .out_whitespace_overflow (out_whitespace_overflow)
  );

endmodule

[rtl/core/jtcf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtcf_datapath
// String/escape tracking, held comma and whitespace buffer, per-request
// emission plan and the output register.
// ----------------------------------------------------------------------------
module jtcf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  jtcf_pkg::ctl_cmd_t  cmd,
  output jtcf_pkg::dp_sts_t   sts,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_body,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last_of_run,
  output logic                out_body_done,
  output logic                out_whitespace_overflow
);
  import jtcf_pkg::*;

  logic             inside_r, inside_nxt;
  logic             esc_r, esc_nxt;
  logic             held_r, held_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       buf_r [SPACE_DEPTH];
  logic             buf_we;

  // plan of the request being emitted
  logic [7:0]       c_r;
  logic             eob_r;
  logic             ovf_r, ovf_nxt;
  logic             pcomma_nxt;
  logic [CNT_W-1:0] pn_r, pn_nxt;
  logic             ptail_r, ptail_nxt;
  logic [IDX_W-1:0] idx_r;

  logic             ov_r;
  logic [7:0]       ob_r;
  logic             olast_r, odone_r, oovf_r;

  logic is_space, is_close, cnt_full, rel_normal;

  always_comb begin
    is_space = (in_data_byte == 8'h20) ||
               (in_data_byte >= 8'h09 && in_data_byte <= 8'h0D);
    is_close = (in_data_byte == CH_RBRACE) || (in_data_byte == CH_RBRACKET);
    cnt_full = (cnt_r == CNT_W'(SPACE_DEPTH));

    inside_nxt = inside_r;
    esc_nxt    = esc_r;
    held_nxt   = held_r;
    cnt_nxt    = cnt_r;
    buf_we     = 1'b0;
    ovf_nxt    = 1'b0;
    pcomma_nxt = 1'b0;
    pn_nxt     = '0;
    ptail_nxt  = 1'b0;
    rel_normal = 1'b1;

    if (held_r) begin
      if (is_space) begin
        rel_normal = 1'b0;
        if (!cnt_full) begin
          buf_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (in_end_of_body) begin
            pcomma_nxt = 1'b1;
            pn_nxt     = cnt_r + CNT_W'(1);
          end
        end else begin
          ovf_nxt    = 1'b1;
          pcomma_nxt = 1'b1;
          pn_nxt     = cnt_r;
          ptail_nxt  = 1'b1;
          held_nxt   = 1'b0;
          cnt_nxt    = '0;
        end
      end else if (is_close) begin
        // comma dropped, buffered whitespace kept
        rel_normal = 1'b0;
        pn_nxt     = cnt_r;
        ptail_nxt  = 1'b1;
        held_nxt   = 1'b0;
        cnt_nxt    = '0;
      end else begin
        pcomma_nxt = 1'b1;
        pn_nxt     = cnt_r;
        held_nxt   = 1'b0;
        cnt_nxt    = '0;
      end
    end

    if (rel_normal) begin
      if (inside_r) begin
        ptail_nxt = 1'b1;
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (in_data_byte == CH_BACKSLASH) begin
          esc_nxt = 1'b1;
        end else if (in_data_byte == CH_QUOTE) begin
          inside_nxt = 1'b0;
        end
      end else if (in_data_byte == CH_QUOTE) begin
        inside_nxt = 1'b1;
        ptail_nxt  = 1'b1;
      end else if (in_data_byte == CH_COMMA) begin
        if (in_end_of_body) begin
          ptail_nxt = 1'b1;
        end else begin
          held_nxt = 1'b1;
          cnt_nxt  = '0;
        end
      end else begin
        ptail_nxt = 1'b1;
      end
    end

    if (in_end_of_body) begin
      inside_nxt = 1'b0;
      esc_nxt    = 1'b0;
      held_nxt   = 1'b0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      esc_r    <= 1'b0;
      held_r   <= 1'b0;
      cnt_r    <= '0;
      pn_r     <= '0;
      ptail_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (cmd.accept) begin
        inside_r <= inside_nxt;
        esc_r    <= esc_nxt;
        held_r   <= held_nxt;
        cnt_r    <= cnt_nxt;
        pn_r     <= pn_nxt;
        ptail_r  <= ptail_nxt;
        idx_r    <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_r   <= in_data_byte;
      eob_r <= in_end_of_body;
      ovf_r <= ovf_nxt;
    end
    if (cmd.accept && buf_we) begin
      buf_r[cnt_r[IDX_W-1:0]] <= in_data_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.sel)
        SEL_COMMA: ob_r <= CH_COMMA;
        SEL_BUF:   ob_r <= buf_r[idx_r];
        SEL_TAIL:  ob_r <= c_r;
        default:   ob_r <= c_r;
      endcase
      olast_r <= cmd.last;
      odone_r <= cmd.last & eob_r;
      oovf_r  <= ovf_r;
    end
  end

  always_comb begin
    sts.out_free  = !ov_r || out_ready;
    sts.comma_nxt = pcomma_nxt;
    sts.buf_nxt   = (pn_nxt != '0);
    sts.tail_nxt  = ptail_nxt;
    sts.buf_any   = (pn_r != '0);
    sts.tail      = ptail_r;
    sts.idx_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == pn_r);
  end

  assign out_valid               = ov_r;
  assign out_byte                = ob_r;
  assign out_last_of_run         = olast_r;
  assign out_body_done           = odone_r;
  assign out_whitespace_overflow = oovf_r;

endmodule

[rtl/core/jtcf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtcf_ctrl
// Sequencer: accepts a request, then steps through comma, buffered whitespace
// and tail byte, one result per cycle when the output register is free.
// ----------------------------------------------------------------------------
module jtcf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jtcf_pkg::dp_sts_t  sts,
  output jtcf_pkg::ctl_cmd_t cmd
);
  import jtcf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COMMA = 2'd1;
  localparam logic [1:0] ST_BUF   = 2'd2;
  localparam logic [1:0] ST_TAIL  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.accept  = 1'b0;
    cmd.load    = 1'b0;
    cmd.sel     = SEL_TAIL;
    cmd.last    = 1'b0;
    cmd.idx_inc = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.comma_nxt)     state_nxt = ST_COMMA;
          else if (sts.buf_nxt)  state_nxt = ST_BUF;
          else if (sts.tail_nxt) state_nxt = ST_TAIL;
        end
      end
      ST_COMMA: begin
        cmd.sel  = SEL_COMMA;
        cmd.last = !sts.buf_any && !sts.tail;
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.buf_any)   state_nxt = ST_BUF;
          else if (sts.tail) state_nxt = ST_TAIL;
          else               state_nxt = ST_IDLE;
        end
      end
      ST_BUF: begin
        cmd.sel  = SEL_BUF;
        cmd.last = sts.idx_last && !sts.tail;
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (!sts.idx_last) cmd.idx_inc = 1'b1;
          else if (sts.tail) state_nxt = ST_TAIL;
          else               state_nxt = ST_IDLE;
        end
      end
      ST_TAIL: begin
        cmd.sel  = SEL_TAIL;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[tb/json_trailing_comma_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_trailing_comma_filter_test
// Self-checking bench for the trailing-comma filter. Text bytes go in over a
// valid/ready channel and are run through a behavioral model of the comma
// stripper; every cleaned byte that leaves the block is compared field by
// field with the model's queue. Directed tests cover byte extremes, string
// and escape tracking, dropped and released commas and a full whitespace
// buffer; random JSON-like bodies with random stalls on both sides follow,
// and the run ends with a stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module json_trailing_comma_filter_test;
  import jtcf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       ovf;
  } clean_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_body = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       out_body_done;
  logic       out_whitespace_overflow;

  // model state
  logic        m_in_string;
  logic        m_escape;
  logic        m_comma_held;
  logic [7:0]  m_space_buf [SPACE_DEPTH];
  int          m_space_cnt;

  clean_byte_t cleaned_q[$];
  logic [7:0]  run_bytes[$];
  logic [7:0]  body_q[$];

  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          req_sent = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  json_trailing_comma_filter u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_data_byte            (in_data_byte),
    .in_end_of_body          (in_end_of_body),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_byte                (out_byte),
    .out_last_of_run         (out_last_of_run),
    .out_body_done           (out_body_done),
    .out_whitespace_overflow (out_whitespace_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // comma first, then the buffered whitespace
  function automatic void release_comma();
    run_bytes.push_back(CH_COMMA);
    for (int i = 0; i < m_space_cnt; i++) run_bytes.push_back(m_space_buf[i]);
    m_comma_held = 1'b0;
    m_space_cnt = 0;
  endfunction

  function automatic void strip_predict(input logic [7:0] b, input logic eob);
    logic        ovf;
    logic        taken;
    clean_byte_t r;
    ovf = 1'b0;
    taken = 1'b0;
    run_bytes.delete();
    if (m_comma_held) begin
      if (is_space(b)) begin
        if (m_space_cnt < SPACE_DEPTH) begin
          m_space_buf[m_space_cnt] = b;
          m_space_cnt++;
          if (eob) release_comma();
        end else begin
          ovf = 1'b1;
          release_comma();
          run_bytes.push_back(b);
        end
        taken = 1'b1;
      end else if (b == CH_RBRACE || b == CH_RBRACKET) begin
        // trailing comma: keep the whitespace, lose the comma
        for (int i = 0; i < m_space_cnt; i++) run_bytes.push_back(m_space_buf[i]);
        m_comma_held = 1'b0;
        m_space_cnt = 0;
        run_bytes.push_back(b);
        taken = 1'b1;
      end else begin
        release_comma();
      end
    end
    if (!taken) begin
      if (m_in_string) begin
        run_bytes.push_back(b);
        if (m_escape) m_escape = 1'b0;
        else if (b == CH_BACKSLASH) m_escape = 1'b1;
        else if (b == CH_QUOTE) m_in_string = 1'b0;
      end else if (b == CH_QUOTE) begin
        m_in_string = 1'b1;
        run_bytes.push_back(b);
      end else if (b == CH_COMMA) begin
        if (eob) begin
          run_bytes.push_back(b);
        end else begin
          m_comma_held = 1'b1;
          m_space_cnt = 0;
        end
      end else begin
        run_bytes.push_back(b);
      end
    end
    foreach (run_bytes[k]) begin
      r.data = run_bytes[k];
      r.ovf = ovf;
      r.last = (k == run_bytes.size() - 1);
      r.done = r.last && eob;
      cleaned_q.push_back(r);
    end
    if (eob) begin
      m_in_string = 1'b0;
      m_escape = 1'b0;
      m_comma_held = 1'b0;
      m_space_cnt = 0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    strip_predict(b, eob);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_body <= eob;
    do @(posedge clk); while (!in_ready);
    req_sent++;
  endtask

  task automatic send_text(input string s, input bit eob_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eob_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic void push_space_run();
    int len;
    // now and then long enough to fill the buffer
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
    repeat (len) body_q.push_back(pick_space());
  endfunction

  task automatic send_random_body();
    int m;
    body_q.delete();
    repeat ($urandom_range(2, 12)) begin
      case ($urandom_range(0, 6))
        0, 1: begin
          body_q.push_back(CH_COMMA);
          push_space_run();
          body_q.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
        end
        2: begin
          body_q.push_back(CH_COMMA);
          push_space_run();
          body_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        end
        3: begin
          body_q.push_back(CH_QUOTE);
          m = $urandom_range(0, 6);
          repeat (m) begin
            case ($urandom_range(0, 5))
              0: begin
                body_q.push_back(CH_BACKSLASH);
                body_q.push_back($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(32, 126)));
              end
              1:       body_q.push_back(CH_COMMA);
              2:       body_q.push_back(CH_RBRACE);
              default: body_q.push_back(8'($urandom_range(32, 126)));
            endcase
          end
          // sometimes leave the string open
          if ($urandom_range(0, 5) != 0) body_q.push_back(CH_QUOTE);
        end
        4: body_q.push_back(8'($urandom_range(0, 255)));
        5: push_space_run();
        default: body_q.push_back($urandom_range(0, 1) ? 8'h7B : 8'h5B);
      endcase
    end
    foreach (body_q[i]) send_byte(body_q[i], i == body_q.size() - 1);
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    // comma on the last byte of a body is always kept
    send_byte(CH_COMMA, 1'b1);
  endtask

  task automatic test_string_tracking();
    // commas and closers inside the string pass, escaped quote does not close it
    send_text("\"a,}\\\"\\\\\",]", 1'b1);
  endtask

  task automatic test_trailing_comma();
    send_text("[1, \t\n]", 1'b1);
    // released comma keeps its whitespace, held comma flushed at end of body
    send_text("[1,\r2,", 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h0C, 1'b1);
  endtask

  task automatic test_space_overflow();
    send_byte(CH_COMMA, 1'b0);
    repeat (SPACE_DEPTH + 1) send_byte(8'h20, 1'b0);
    send_byte(CH_RBRACKET, 1'b1);
  endtask

  task automatic test_random_bodies(input int target);
    idle_on = 1'b1;
    while (req_sent < target) send_random_body();
  endtask

  task automatic test_steady_stream(input int target);
    idle_on = 1'b0;
    while (req_sent < target) send_random_body();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    clean_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cleaned_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual byte %02h", $time, out_byte);
        err_cnt++;
      end else begin
        want = cleaned_q.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
          err_cnt++;
        end
        if (out_last_of_run !== want.last) begin
          $display("%0t: out_last_of_run expected %0b actual %0b", $time, want.last,
                   out_last_of_run);
          err_cnt++;
        end
        if (out_body_done !== want.done) begin
          $display("%0t: out_body_done expected %0b actual %0b", $time, want.done,
                   out_body_done);
          err_cnt++;
        end
        if (out_whitespace_overflow !== want.ovf) begin
          $display("%0t: out_whitespace_overflow expected %0b actual %0b", $time, want.ovf,
                   out_whitespace_overflow);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    m_in_string = 1'b0;
    m_escape = 1'b0;
    m_comma_held = 1'b0;
    m_space_cnt = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_byte_extremes();
    test_string_tracking();
    test_trailing_comma();
    test_space_overflow();
    test_random_bodies(250);
    test_steady_stream(305);
    @(negedge clk);
    in_valid <= 1'b0;
    while (cleaned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && cleaned_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/jtcf_pkg.sv
rtl/core/jtcf_datapath.sv
rtl/core/jtcf_ctrl.sv
rtl/core/json_trailing_comma_filter.sv
tb/json_trailing_comma_filter_test.sv
